// File: rtl/sorted_priority_queue_defines.svh
// Assertion macros shared by the sorted priority queue RTL
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// Types and constants of the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PRIO_W      = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned DEF_CAPACITY = 16;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/spq_if.sv
// Valid/ready channel interfaces for queue commands and results
`default_nettype none

interface spq_in_if
  import spq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] data_in;
  logic signed [PRIO_W-1:0] priority_in;

  modport source (output valid, output cmd, output data_in, output priority_in,
                  input ready);
  modport sink   (input valid, input cmd, input data_in, input priority_in,
                  output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_data;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] front_data;
  logic                     front_valid;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output popped_data, output status, output front_data,
                  output front_valid, output occupancy, input ready);
  modport sink   (input valid, input popped_data, input status, input front_data,
                  input front_valid, input occupancy, output ready);
endinterface

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue: one memory, one comparator and a small sequencer.
// Entries sit in a circular buffer in ascending priority order, front at the head
// pointer; an enqueue goes ahead of the first entry whose priority is greater than or
// equal to its own, a dequeue returns the front. Each command yields one result with
// the outcome, the new front and the occupancy. The queue takes one command at a time
// and is ready again once its result sits in the output register. An enqueue walks
// the entries in a read-and-compare pass up to the insert point, then moves the entries
// behind it back by one slot in a read-and-write pass, both through the single memory read
// port; a dequeue reads the front, advances the head and reads the new front. An enqueue to
// a full queue only reads the front, and a dequeue from an empty queue goes straight to the
// result. A finished result waits while the output register stays occupied. The store
// needs no clearing after reset.
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  spq_in_if.sink   in_i,
  spq_out_if.source out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_SCAN     = 10'b00_0000_0010,
    ST_CMP      = 10'b00_0000_0100,
    ST_SHIFT_RD = 10'b00_0000_1000,
    ST_SHIFT_WR = 10'b00_0001_0000,
    ST_INSERT   = 10'b00_0010_0000,
    ST_POP      = 10'b00_0100_0000,
    ST_POP_TAKE = 10'b00_1000_0000,
    ST_FRONT    = 10'b01_0000_0000,
    ST_RESULT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] j_q, j_d;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;
  logic signed [DATA_W-1:0] popped_q, popped_d;
  logic [STATUS_W-1:0]      status_q, status_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_popped_q, out_popped_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;
  logic signed [DATA_W-1:0] out_front_q, out_front_d;
  logic                     out_fvalid_q, out_fvalid_d;
  logic [OCC_W-1:0]         out_occ_q, out_occ_d;

  entry_t        mem_q [CAPACITY];
  entry_t        rd_data_q;
  logic [CW-1:0] rd_lidx, wr_lidx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  entry_t        wr_entry;
  logic          in_acc, out_free, is_full, is_empty;

  // Map a position in sorted order to a physical slot of the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(l);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return AW'(s);
  endfunction

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign is_full    = (count_q == CW'(CAPACITY));
  assign is_empty   = (count_q == '0);

  assign rd_addr = phys(head_q, rd_lidx);
  assign wr_addr = phys(head_q, wr_lidx);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    idx_d        = idx_q;
    j_d          = j_q;
    data_d       = data_q;
    prio_d       = prio_q;
    popped_d     = popped_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_popped_d = out_popped_q;
    out_status_d = out_status_q;
    out_front_d  = out_front_q;
    out_fvalid_d = out_fvalid_q;
    out_occ_d    = out_occ_q;
    rd_lidx      = '0;
    wr_lidx      = idx_q;
    wr_en        = 1'b0;
    wr_entry     = rd_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          data_d   = in_i.data_in;
          prio_d   = in_i.priority_in;
          popped_d = '0;
          status_d = STATUS_OK;
          idx_d    = '0;
          if (in_i.cmd == CMD_ENQ) begin
            if (is_full) begin
              status_d = STATUS_FULL;
              state_d  = ST_FRONT;
            end else begin
              state_d = ST_SCAN;
            end
          end else if (is_empty) begin
            status_d = STATUS_EMPTY;
            state_d  = ST_RESULT;
          end else begin
            state_d = ST_POP;
          end
        end
      end
      ST_SCAN: begin
        rd_lidx = idx_q;
        if (idx_q == count_q) begin
          // ran past the tail: append
          j_d     = count_q;
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if ($signed(rd_data_q.prio) >= prio_q) begin
          j_d     = count_q;
          state_d = ST_SHIFT_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SHIFT_RD: begin
        rd_lidx = j_q - CW'(1);
        if (j_q == idx_q) begin
          state_d = ST_INSERT;
        end else begin
          state_d = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        // move one entry back by a slot, working from the tail
        wr_en    = 1'b1;
        wr_lidx  = j_q;
        wr_entry = rd_data_q;
        j_d      = j_q - CW'(1);
        state_d  = ST_SHIFT_RD;
      end
      ST_INSERT: begin
        wr_en         = 1'b1;
        wr_lidx       = idx_q;
        wr_entry.prio = prio_q;
        wr_entry.data = data_q;
        count_d       = count_q + CW'(1);
        state_d       = ST_FRONT;
      end
      ST_POP: begin
        state_d = ST_POP_TAKE;
      end
      ST_POP_TAKE: begin
        popped_d = rd_data_q.data;
        head_d   = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
        count_d  = count_q - CW'(1);
        state_d  = ST_FRONT;
      end
      ST_FRONT: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_popped_d = popped_q;
          out_status_d = status_q;
          out_front_d  = is_empty ? '0 : rd_data_q.data;
          out_fvalid_d = !is_empty;
          out_occ_d    = OCC_W'(count_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      idx_q       <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      idx_q       <= idx_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q       <= data_d;
    prio_q       <= prio_d;
    popped_q     <= popped_d;
    status_q     <= status_d;
    out_popped_q <= out_popped_d;
    out_status_q <= out_status_d;
    out_front_q  <= out_front_d;
    out_fvalid_q <= out_fvalid_d;
    out_occ_q    <= out_occ_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_entry;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.popped_data = out_popped_q;
  assign out_o.status      = out_status_q;
  assign out_o.front_data  = out_front_q;
  assign out_o.front_valid = out_fvalid_q;
  assign out_o.occupancy   = out_occ_q;

  `SPQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY),
                  "stored count exceeds capacity")
  `SPQ_ASSERT_NOW(a_pop_nonempty, clk_i, rst_ni, state_q == ST_POP_TAKE, count_q != '0,
                  "dequeue taken from an empty store")
  `SPQ_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, state_q == ST_INSERT,
                   count_q == $past(count_q) + CW'(1), "insert did not grow the count")
  `SPQ_ASSERT_NOW(a_shift_order, clk_i, rst_ni, state_q == ST_SHIFT_WR, j_q > idx_q,
                  "shift moved past the insert point")
  `SPQ_ASSERT_NOW(a_full_flag, clk_i, rst_ni,
                  state_q == ST_RESULT && out_free && status_q == STATUS_FULL,
                  count_q == CW'(CAPACITY), "full status reported below capacity")

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the sorted priority queue: directed rows, then random traffic
`timescale 1ns / 100ps

module testbench;
  import spq_pkg::*;

  localparam int unsigned DEPTH        = DEF_CAPACITY;
  localparam int unsigned NUM_ROWS     = 23;
  localparam int unsigned RAND_ITEMS   = 450;
  localparam int unsigned CALM_ITEMS   = 80;
  localparam int unsigned HOLD_START   = 90;
  localparam int unsigned HOLD_END     = 130;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PAUSE_AT     = 200;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] front;
    logic                     front_vld;
    logic [OCC_W-1:0]         occ;
  } qresult_t;

  // typed rows carry a literal result; the others take the predicted one
  typedef struct packed {
    logic     typed;
    qresult_t res;
  } row_note_t;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
    row_note_t         note;
  } op_row_t;

  localparam qresult_t NO_RES = '0;

  localparam op_row_t DIRECTED_OPS [NUM_ROWS] = '{
    '{CMD_DEQ, 32'h0000_0000, 32'h0000_0000,
      '{1'b1, '{32'h0000_0000, STATUS_EMPTY, 32'h0000_0000, 1'b0, 5'd0}}},
    '{CMD_ENQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      '{1'b1, '{32'h0000_0000, STATUS_OK, 32'h7FFF_FFFF, 1'b1, 5'd1}}},
    '{CMD_ENQ, 32'h8000_0000, 32'h8000_0000,
      '{1'b1, '{32'h0000_0000, STATUS_OK, 32'h8000_0000, 1'b1, 5'd2}}},
    '{CMD_ENQ, 32'h0000_0000, 32'h0000_0000,
      '{1'b1, '{32'h0000_0000, STATUS_OK, 32'h8000_0000, 1'b1, 5'd3}}},
    // equal priority goes in front of the entry already there
    '{CMD_ENQ, 32'hFFFF_FFFF, 32'h8000_0000,
      '{1'b1, '{32'h0000_0000, STATUS_OK, 32'hFFFF_FFFF, 1'b1, 5'd4}}},
    '{CMD_ENQ, 32'h0000_0001, 32'h7FFF_FFFF, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'h0000_0002, 32'h0000_0000, '{1'b0, NO_RES}},
    '{CMD_DEQ, 32'hAAAA_AAAA, 32'h5555_5555,
      '{1'b1, '{32'hFFFF_FFFF, STATUS_OK, 32'h8000_0000, 1'b1, 5'd5}}},
    '{CMD_ENQ, 32'h1234_5678, 32'hFFFF_FFFB, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'hDEAD_BEEF, 32'h0000_0064, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'h5555_5555, 32'hFFFF_FF9C, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'hAAAA_AAAA, 32'h0000_0000, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'h0F0F_0F0F, 32'h0000_0007, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'hF0F0_F0F0, 32'h0000_0007, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'h0000_0100, 32'h0000_0003, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'h7FFF_FFFE, 32'h7FFF_FFFE, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'h8000_0001, 32'h8000_0001, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'hCAFE_F00D, 32'h0000_002A, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'h1357_9BDF, 32'hFFFF_FFFF, '{1'b0, NO_RES}},
    // queue is full now: drop the item
    '{CMD_ENQ, 32'h2468_1357, 32'h8000_0000,
      '{1'b1, '{32'h0000_0000, STATUS_FULL, 32'h8000_0000, 1'b1, 5'd16}}},
    '{CMD_DEQ, 32'hFFFF_0000, 32'h0000_FFFF, '{1'b0, NO_RES}},
    '{CMD_ENQ, 32'h0000_0000, 32'h8000_0000, '{1'b0, NO_RES}},
    '{CMD_DEQ, 32'h0000_0000, 32'h0000_0000, '{1'b0, NO_RES}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  cmd_if ();
  spq_out_if res_if ();

  sorted_priority_queue #(
    .CAPACITY(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  entry_t    sorted_store[$];
  qresult_t  pending_results[$];
  row_note_t row_notes[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  qresult_t  got_res;
  qresult_t  want_res;
  qresult_t  calc_res;
  row_note_t cur_note;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one command to the predicted store and return its result
  function automatic qresult_t predict_queue_op(input logic cmd,
                                                input logic signed [DATA_W-1:0] data,
                                                input logic signed [PRIO_W-1:0] prio);
    qresult_t r;
    entry_t   e;
    int       pos;
    r = '0;
    if (cmd == CMD_ENQ) begin
      if (sorted_store.size() >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = sorted_store.size();
        // scan from the back so the first entry at or above prio wins
        for (int i = sorted_store.size() - 1; i >= 0; i--) begin
          if ($signed(sorted_store[i].prio) >= prio) pos = i;
        end
        e.prio = prio;
        e.data = data;
        sorted_store.insert(pos, e);
        r.status = STATUS_OK;
      end
    end else begin
      if (sorted_store.size() == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        e = sorted_store.pop_front();
        r.popped = e.data;
        r.status = STATUS_OK;
      end
    end
    if (sorted_store.size() != 0) begin
      r.front     = sorted_store[0].data;
      r.front_vld = 1'b1;
    end
    r.occ = OCC_W'(sorted_store.size());
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Offer one command and hold it until the queue takes the transaction
  task automatic send_op(input logic cmd, input logic [DATA_W-1:0] data,
                         input logic [PRIO_W-1:0] prio, input row_note_t note);
    row_notes.push_back(note);
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= cmd;
    cmd_if.data_in     <= data;
    cmd_if.priority_in <= prio;
    do @(posedge clk_i); while (!cmd_if.ready);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got_res = '{res_if.popped_data, res_if.status, res_if.front_data,
                    res_if.front_valid, res_if.occupancy};
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with no command pending: expected none, actual %h",
                   $time, got_res);
        end else begin
          want_res = pending_results.pop_front();
          report_field("popped_data", want_res.popped, got_res.popped);
          report_field("status", 32'(want_res.status), 32'(got_res.status));
          report_field("front_data", want_res.front, got_res.front);
          report_field("front_valid", 32'(want_res.front_vld), 32'(got_res.front_vld));
          report_field("occupancy", 32'(want_res.occ), 32'(got_res.occ));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        calc_res = predict_queue_op(cmd_if.cmd, cmd_if.data_in, cmd_if.priority_in);
        cur_note = row_notes.pop_front();
        pending_results.push_back(cur_note.typed ? cur_note.res : calc_res);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    res_if.ready = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned       enq_pct;
    logic              op;
    logic [DATA_W-1:0] rdata;
    logic [PRIO_W-1:0] rprio;
    cmd_if.valid       = 1'b0;
    cmd_if.cmd         = CMD_ENQ;
    cmd_if.data_in     = '0;
    cmd_if.priority_in = '0;
    enq_pct = 50;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_op(DIRECTED_OPS[r].cmd, DIRECTED_OPS[r].data, DIRECTED_OPS[r].prio,
              DIRECTED_OPS[r].note);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // swing the mix so the queue fills up and drains repeatedly
      if (n % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 85;
          1:       enq_pct = 50;
          default: enq_pct = 15;
        endcase
      end
      if (n == HOLD_START) begin
        enq_pct = 85;
        hold_req = 1'b1;
      end
      calm = (n >= RAND_ITEMS - CALM_ITEMS);

      if (n == PAUSE_AT) begin
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end else if (!calm && !(n >= HOLD_START && n < HOLD_END) &&
                   $urandom_range(0, 5) == 0) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end

      op = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      rdata = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rprio = PRIO_W'($signed($urandom_range(0, 7)) - 4);
        4: begin
          case ($urandom_range(0, 3))
            0:       rprio = 32'h8000_0000;
            1:       rprio = 32'h7FFF_FFFF;
            2:       rprio = 32'h0000_0000;
            default: rprio = 32'hFFFF_FFFF;
          endcase
        end
        default: rprio = $urandom;
      endcase
      send_op(op, rdata, rprio, '{1'b0, NO_RES});
    end

    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
